>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared codes, reset values and the per-tick result record of the I2C
// bus master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// command codes carried with each tick; other codes act as a bare tick
	localparam logic [2:0] ACT_TICK      = 3'd0;
	localparam logic [2:0] ACT_START     = 3'd1;
	localparam logic [2:0] ACT_STOP      = 3'd2;
	localparam logic [2:0] ACT_WRITE     = 3'd3;
	localparam logic [2:0] ACT_CHECK_ACK = 3'd4;
	localparam logic [2:0] ACT_READ      = 3'd5;

	// configuration register indexes
	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_TIMEOUT = 1'b1;

	// register reset values
	localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

	// bits per bus byte
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// one result item, after the tick's update
	typedef struct packed {
		logic       rejected;
		logic       ack_error;
		logic [7:0] read_byte;
		logic       done;
		logic       busy;
		logic       sda_enable;
		logic       sda_out;
		logic       scl_level;
	} result_t;

endpackage

>>> rtl/i2cm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_core
// Bus step sequencer: holds phase, counters and pin registers, and advances
// them by one tick for every item handed in with step high.
// ----------------------------------------------------------------------------
module i2cm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               step,
	input  logic [2:0]         action,
	input  logic [7:0]         data_byte,
	input  logic               ack_after_read,
	input  logic               sda_level,
	output i2cm_pkg::result_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_A, PH_WR_B, PH_WR_C,
		PH_AK_A, PH_AK_B, PH_AK_P, PH_RD_A, PH_RD_B, PH_RA_A, PH_RA_B
	} phase_t;

	logic [7:0] half_period_q, ack_timeout_q;

	phase_t     ph_q, ph_n, tgt;
	logic [3:0] bc_q, bc_n;
	logic [7:0] shift_q, shift_n;
	logic [7:0] delay_q, delay_n;
	logic [7:0] poll_q, poll_n;
	logic       ackc_q, ackc_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       sden_q, sden_n;
	logic       err_q, err_n;
	logic [7:0] hold_q, hold_n;

	logic       is_cmd, fin, rej, do_enter, do_poll;
	logic [7:0] step_delay;

	assign is_cmd = (action >= i2cm_pkg::ACT_START) && (action <= i2cm_pkg::ACT_READ);
	// a zero half period acts as one tick
	assign step_delay = (half_period_q == 8'd0) ? 8'd0 : half_period_q - 8'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cm_pkg::HALF_PERIOD_RESET;
			ack_timeout_q <= i2cm_pkg::ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == i2cm_pkg::CFG_HALF_PERIOD) half_period_q <= cfg_data;
			else ack_timeout_q <= cfg_data;
		end
	end

	// next state for one tick
	always_comb begin
		ph_n     = ph_q;
		bc_n     = bc_q;
		shift_n  = shift_q;
		delay_n  = delay_q;
		poll_n   = poll_q;
		ackc_n   = ackc_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		sden_n   = sden_q;
		err_n    = err_q;
		hold_n   = hold_q;
		fin      = 1'b0;
		rej      = 1'b0;
		do_enter = 1'b0;
		do_poll  = 1'b0;
		tgt      = PH_IDLE;

		if (ph_q != PH_IDLE) begin
			if (is_cmd) rej = 1'b1;
			if (ph_q == PH_AK_P) begin
				do_poll = 1'b1;
			end else if (delay_q != 8'd0) begin
				delay_n = delay_q - 8'd1;
			end else begin
				case (ph_q)
					PH_ST_A: begin do_enter = 1'b1; tgt = PH_ST_B; end
					PH_ST_B: begin scl_n = 1'b0; fin = 1'b1; end
					PH_SP_A: begin do_enter = 1'b1; tgt = PH_SP_B; end
					PH_SP_B: fin = 1'b1;
					PH_WR_A: begin do_enter = 1'b1; tgt = PH_WR_B; end
					PH_WR_B: begin do_enter = 1'b1; tgt = PH_WR_C; end
					PH_WR_C: begin
						bc_n = bc_q + 4'd1;
						if (bc_n >= i2cm_pkg::BYTE_BITS) fin = 1'b1;
						else begin do_enter = 1'b1; tgt = PH_WR_A; end
					end
					PH_AK_A: begin do_enter = 1'b1; tgt = PH_AK_B; end
					PH_AK_B: begin poll_n = 8'd0; do_poll = 1'b1; end
					PH_RD_A: begin do_enter = 1'b1; tgt = PH_RD_B; end
					PH_RD_B: begin
						shift_n  = {shift_q[6:0], sda_level};
						bc_n     = bc_q + 4'd1;
						do_enter = 1'b1;
						tgt      = (bc_n >= i2cm_pkg::BYTE_BITS) ? PH_RA_A : PH_RD_A;
					end
					PH_RA_A: begin do_enter = 1'b1; tgt = PH_RA_B; end
					PH_RA_B: begin scl_n = 1'b0; hold_n = shift_q; fin = 1'b1; end
					default: fin = 1'b1;
				endcase
			end
		end else if (is_cmd) begin
			bc_n = 4'd0;
			do_enter = 1'b1;
			case (action)
				i2cm_pkg::ACT_START: tgt = PH_ST_A;
				i2cm_pkg::ACT_STOP:  tgt = PH_SP_A;
				i2cm_pkg::ACT_WRITE: begin shift_n = data_byte; tgt = PH_WR_A; end
				i2cm_pkg::ACT_CHECK_ACK: begin
					err_n  = 1'b0;
					poll_n = 8'd0;
					tgt    = PH_AK_A;
				end
				default: begin
					ackc_n  = ack_after_read;
					shift_n = 8'd0;
					tgt     = PH_RD_A;
				end
			endcase
		end

		// acknowledge poll: low SDA ends the check, too many highs abort with a stop
		if (do_poll) begin
			if (!sda_level) begin
				scl_n = 1'b0;
				fin   = 1'b1;
			end else begin
				poll_n = poll_n + 8'd1;
				if (poll_n >= ack_timeout_q) begin
					err_n    = 1'b1;
					do_enter = 1'b1;
					tgt      = PH_SP_A;
				end else begin
					ph_n    = PH_AK_P;
					delay_n = 8'd0;
				end
			end
		end

		if (fin) begin
			ph_n    = PH_IDLE;
			delay_n = 8'd0;
		end

		// enter a bus step: set its pins and load the step delay
		if (do_enter) begin
			ph_n    = tgt;
			delay_n = step_delay;
			case (tgt)
				PH_ST_A: begin sden_n = 1'b1; sda_n = 1'b1; scl_n = 1'b1; end
				PH_ST_B: sda_n = 1'b0;
				PH_SP_A: begin sden_n = 1'b1; sda_n = 1'b0; scl_n = 1'b1; end
				PH_SP_B: sda_n = 1'b1;
				PH_WR_A: begin
					sden_n  = 1'b1;
					scl_n   = 1'b0;
					sda_n   = shift_n[7];
					shift_n = {shift_n[6:0], 1'b0};
				end
				PH_WR_B: scl_n = 1'b1;
				PH_WR_C: scl_n = 1'b0;
				PH_AK_A: sden_n = 1'b0;
				PH_AK_B: scl_n = 1'b1;
				PH_RD_A: begin sden_n = 1'b0; scl_n = 1'b0; end
				PH_RD_B: scl_n = 1'b1;
				PH_RA_A: begin scl_n = 1'b0; sden_n = 1'b1; sda_n = ~ackc_n; end
				PH_RA_B: scl_n = 1'b1;
				default: delay_n = 8'd0;
			endcase
		end
	end

	// result of this tick, taken from the updated state
	always_comb begin
		res.scl_level  = scl_n;
		res.sda_out    = sden_n & sda_n;
		res.sda_enable = sden_n;
		res.busy       = (ph_n != PH_IDLE);
		res.done       = fin;
		res.read_byte  = hold_n;
		res.ack_error  = err_n;
		res.rejected   = rej;
	end

	// hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_IDLE;
			bc_q    <= 4'd0;
			shift_q <= 8'd0;
			delay_q <= 8'd0;
			poll_q  <= 8'd0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			sden_q  <= 1'b1;
			err_q   <= 1'b0;
			hold_q  <= 8'd0;
		end else if (step) begin
			ph_q    <= ph_n;
			bc_q    <= bc_n;
			shift_q <= shift_n;
			delay_q <= delay_n;
			poll_q  <= poll_n;
			ackc_q  <= ackc_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			sden_q  <= sden_n;
			err_q   <= err_n;
			hold_q  <= hold_n;
		end
	end

endmodule

>>> rtl/i2c_bus_master_unit.sv
`timescale 1ns / 1ps
// The result item for a tick is registered in the output register, or in the skid entry while that register is held.
// The unit takes one tick per clock cycle while the skid entry is empty.
// A two-entry output buffer keeps ticks flowing while one result waits downstream.
// Reset (arst_n low): sequencer idle, SCL and SDA driven high, registers at 5 and 250.
// ----------------------------------------------------------------------------
// i2c_bus_master_unit
// I2C master pin sequencer with a streaming tick input and result output.
// ----------------------------------------------------------------------------
module i2c_bus_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// tick items in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte[7:0], ack_after_read[8], sda_level[9], zero
	input  logic [2:0]  s_tuser,  // action[2:0]
	// result items out
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_out[1], sda_enable[2], busy_res[3], done_res[4],
	// read_byte[12:5], ack_error[13], rejected[14], zero
	output logic [15:0] m_tdata
);

	i2cm_pkg::result_t res, out_s1, skid_q;
	logic              out_valid_s1, skid_valid_q;
	logic              accept, pop;

	assign s_tready = ~skid_valid_q;
	assign accept   = s_tvalid & s_tready;
	assign pop      = out_valid_s1 & m_tready;

	i2cm_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.step           (accept),
		.action         (s_tuser),
		.data_byte      (s_tdata[7:0]),
		.ack_after_read (s_tdata[8]),
		.sda_level      (s_tdata[9]),
		.res            (res)
	);

	// output register with skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_s1) begin
			if (skid_valid_q) begin
				out_valid_s1 <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_s1 <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload of the two entries
	always_ff @(posedge clk) begin
		if (pop || !out_valid_s1) begin
			if (skid_valid_q) out_s1 <= skid_q;
			else if (accept) out_s1 <= res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_s1;
	assign m_tdata  = {1'b0, out_s1.rejected, out_s1.ack_error, out_s1.read_byte,
	                   out_s1.done, out_s1.busy, out_s1.sda_enable, out_s1.sda_out,
	                   out_s1.scl_level};

endmodule

>>> test/i2c_pin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_pin_checker
// Watches the tick and result streams of the I2C bus master, runs its own
// model of the pin sequencer on every accepted tick and compares each result
// item, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module i2c_pin_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte[7:0], ack_after_read[8], sda_level[9], zero
	input  logic [2:0]  s_tuser,  // action[2:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_out[1], sda_enable[2], busy_res[3], done_res[4],
	// read_byte[12:5], ack_error[13], rejected[14], zero
	input  logic [15:0] m_tdata,
	output int          mismatches,
	output int          pending,
	output logic        seq_busy,
	output int          results_checked,
	output int          commands_done,
	output int          ack_timeouts,
	output int          rejected_cmds
);
	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		BUS_IDLE, START_HOLD, START_DROP, STOP_HOLD, STOP_RISE,
		WR_SETUP, WR_HIGH, WR_LOW, ACK_RELEASE, ACK_HIGH, ACK_POLL,
		RD_LOW, RD_HIGH, RACK_LOW, RACK_HIGH
	} bus_step_e;

	// configuration copy
	logic [7:0] half_ticks;
	logic [7:0] ack_limit;

	// sequencer model
	bus_step_e  step;
	logic [3:0] bit_cnt;
	logic [7:0] shifter;
	logic [7:0] hold_cnt;
	logic [7:0] polls;
	logic [7:0] read_hold;
	logic       ack_sel;
	logic       scl_q;
	logic       sda_q;
	logic       sda_en_q;
	logic       ack_err;
	logic       finished;

	result_t    pin_results[$];

	function automatic void clear_model();
		half_ticks = HALF_PERIOD_RESET;
		ack_limit  = ACK_TIMEOUT_RESET;
		step       = BUS_IDLE;
		bit_cnt    = '0;
		shifter    = '0;
		hold_cnt   = '0;
		polls      = '0;
		read_hold  = '0;
		ack_sel    = 1'b0;
		scl_q      = 1'b1;
		sda_q      = 1'b1;
		sda_en_q   = 1'b1;
		ack_err    = 1'b0;
		finished   = 1'b0;
	endfunction

	// load a bus step: set its pins and arm its hold time (a zero delay acts as one)
	function automatic void enter_step(bus_step_e nxt);
		logic [7:0] d;
		d = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
		step = nxt;
		hold_cnt = d - 8'd1;
		case (nxt)
		START_HOLD: begin
			sda_en_q = 1'b1;
			sda_q = 1'b1;
			scl_q = 1'b1;
		end
		START_DROP: sda_q = 1'b0;
		STOP_HOLD: begin
			sda_en_q = 1'b1;
			sda_q = 1'b0;
			scl_q = 1'b1;
		end
		STOP_RISE: sda_q = 1'b1;
		WR_SETUP: begin
			sda_en_q = 1'b1;
			scl_q = 1'b0;
			sda_q = shifter[7];
			shifter = shifter << 1;
		end
		WR_HIGH: scl_q = 1'b1;
		WR_LOW: scl_q = 1'b0;
		ACK_RELEASE: sda_en_q = 1'b0;
		ACK_HIGH: scl_q = 1'b1;
		RD_LOW: begin
			sda_en_q = 1'b0;
			scl_q = 1'b0;
		end
		RD_HIGH: scl_q = 1'b1;
		RACK_LOW: begin
			scl_q = 1'b0;
			sda_en_q = 1'b1;
			sda_q = ~ack_sel;
		end
		RACK_HIGH: scl_q = 1'b1;
		default: hold_cnt = 8'd0;
		endcase
	endfunction

	function automatic void end_command();
		step = BUS_IDLE;
		hold_cnt = 8'd0;
		finished = 1'b1;
	endfunction

	// one acknowledge sample: low ends the check, too many highs force a stop
	function automatic void sample_ack(logic sda);
		if (!sda) begin
			scl_q = 1'b0;
			end_command();
		end else begin
			polls = polls + 8'd1;
			if (polls >= ack_limit) begin
				ack_err = 1'b1;
				ack_timeouts++;
				enter_step(STOP_HOLD);
			end else begin
				step = ACK_POLL;
				hold_cnt = 8'd0;
			end
		end
	endfunction

	// move on once the current step has held for its full time
	function automatic void next_step(logic sda);
		case (step)
		START_HOLD: enter_step(START_DROP);
		START_DROP: begin
			scl_q = 1'b0;
			end_command();
		end
		STOP_HOLD: enter_step(STOP_RISE);
		STOP_RISE: end_command();
		WR_SETUP: enter_step(WR_HIGH);
		WR_HIGH: enter_step(WR_LOW);
		WR_LOW: begin
			bit_cnt = bit_cnt + 4'd1;
			if (bit_cnt >= BYTE_BITS) end_command();
			else enter_step(WR_SETUP);
		end
		ACK_RELEASE: enter_step(ACK_HIGH);
		ACK_HIGH: begin
			polls = 8'd0;
			sample_ack(sda);
		end
		RD_LOW: enter_step(RD_HIGH);
		RD_HIGH: begin
			shifter = {shifter[6:0], sda};
			bit_cnt = bit_cnt + 4'd1;
			if (bit_cnt >= BYTE_BITS) enter_step(RACK_LOW);
			else enter_step(RD_LOW);
		end
		RACK_LOW: enter_step(RACK_HIGH);
		RACK_HIGH: begin
			scl_q = 1'b0;
			read_hold = shifter;
			end_command();
		end
		default: end_command();
		endcase
	endfunction

	// advance the model by one tick and build the pins it shows afterwards
	function automatic result_t predict_tick(logic [2:0] act, logic [7:0] db, logic ak,
			logic sda);
		logic    is_cmd;
		logic    rej;
		result_t r;
		is_cmd = (act >= ACT_START) && (act <= ACT_READ);
		rej = 1'b0;
		finished = 1'b0;
		if (step != BUS_IDLE) begin
			rej = is_cmd;
			if (step == ACK_POLL) sample_ack(sda);
			else if (hold_cnt > 8'd0) hold_cnt = hold_cnt - 8'd1;
			else next_step(sda);
		end else if (is_cmd) begin
			bit_cnt = 4'd0;
			case (act)
			ACT_START: enter_step(START_HOLD);
			ACT_STOP: enter_step(STOP_HOLD);
			ACT_WRITE: begin
				shifter = db;
				enter_step(WR_SETUP);
			end
			ACT_CHECK_ACK: begin
				ack_err = 1'b0;
				polls = 8'd0;
				enter_step(ACK_RELEASE);
			end
			default: begin
				ack_sel = ak;
				shifter = 8'd0;
				enter_step(RD_LOW);
			end
			endcase
		end
		if (finished) commands_done++;
		if (rej) rejected_cmds++;
		r.scl_level  = scl_q;
		r.sda_out    = sda_en_q ? sda_q : 1'b0;
		r.sda_enable = sda_en_q;
		r.busy       = (step != BUS_IDLE);
		r.done       = finished;
		r.read_byte  = read_hold;
		r.ack_error  = ack_err;
		r.rejected   = rej;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %0d field %s: expected %0h, got %0h",
					$time, results_checked, name, want, got);
		end
	endfunction

	function automatic void compare_result(result_t want, logic [15:0] raw);
		result_t got;
		got = result_t'(raw[14:0]);
		check_field("scl_level", want.scl_level, got.scl_level);
		check_field("sda_out", want.sda_out, got.sda_out);
		check_field("sda_enable", want.sda_enable, got.sda_enable);
		check_field("busy", want.busy, got.busy);
		check_field("done", want.done, got.done);
		check_field("read_byte", want.read_byte, got.read_byte);
		check_field("ack_error", want.ack_error, got.ack_error);
		check_field("rejected", want.rejected, got.rejected);
		check_field("padding", 0, raw[15]);
	endfunction

	// predict on accepted ticks, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			pin_results.delete();
			mismatches = 0;
			pending = 0;
			seq_busy = 1'b0;
			results_checked = 0;
			commands_done = 0;
			ack_timeouts = 0;
			rejected_cmds = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HALF_PERIOD) half_ticks = cfg_data;
				else ack_limit = cfg_data;
			end
			if (s_tvalid && s_tready)
				pin_results.push_back(predict_tick(s_tuser, s_tdata[7:0], s_tdata[8],
					s_tdata[9]));
			if (m_tvalid && m_tready) begin
				if (pin_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result item %h arrived with no tick outstanding",
							$time, m_tdata);
				end else begin
					compare_result(pin_results.pop_front(), m_tdata);
				end
				results_checked++;
			end
			pending = pin_results.size();
			seq_busy = (step != BUS_IDLE);
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus command ticks into the I2C bus master with the slave's SDA answer
// on each tick, under several delay and acknowledge timeout settings and three
// handshake idling mixes; the pin checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import i2cm_pkg::*;

	// codes outside the command set, taken as bare ticks
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_HALF_PERIOD;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;  // data_byte[7:0], ack_after_read[8], sda_level[9], zero
	logic [2:0]  s_tuser = ACT_TICK;  // action[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// scl_level[0], sda_out[1], sda_enable[2], busy_res[3], done_res[4],
	// read_byte[12:5], ack_error[13], rejected[14], zero
	logic [15:0] m_tdata;

	int   mismatches;
	int   pending;
	logic seq_busy;
	int   results_checked;
	int   commands_done;
	int   ack_timeouts;
	int   rejected_cmds;

	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	i2c_bus_master_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	i2c_pin_checker pin_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatches     (mismatches),
		.pending        (pending),
		.seq_busy       (seq_busy),
		.results_checked(results_checked),
		.commands_done  (commands_done),
		.ack_timeouts   (ack_timeouts),
		.rejected_cmds  (rejected_cmds)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// stall the result side at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic sda_bit(int low_pct);
		return ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
	endfunction

	// hand one tick over; starts and ends on a falling edge
	task automatic send_item(logic [2:0] act, logic [7:0] db, logic ak, logic sl);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'd0, sl, ak, db};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// issue a command, then tick until the sequencer is idle again
	task automatic run_command(logic [2:0] act, logic [7:0] db, logic ak, int low_pct);
		send_item(act, db, ak, sda_bit(low_pct));
		while (seq_busy)
			send_item(($urandom_range(99) < 5) ? 3'($urandom_range(7, 1)) : ACT_TICK,
				8'($urandom), 1'($urandom), sda_bit(low_pct));
	endtask

	// hold the ticks back until every result is in
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic configure(logic [7:0] half, logic [7:0] timeout);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_HALF_PERIOD;
		cfg_data <= half;
		@(negedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= timeout;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// start, a few writes with acknowledge checks or reads, stop
	task automatic transaction();
		run_command(ACT_START, 8'($urandom), 1'($urandom), 50);
		repeat ($urandom_range(3, 1)) begin
			if ($urandom_range(1)) begin
				run_command(ACT_WRITE, 8'($urandom), 1'($urandom), 50);
				run_command(ACT_CHECK_ACK, 8'($urandom), 1'($urandom),
					($urandom_range(3) == 0) ? 0 : 35);
			end else begin
				run_command(ACT_READ, 8'($urandom), 1'($urandom), 50);
			end
		end
		run_command(ACT_STOP, 8'($urandom), 1'($urandom), 50);
	endtask

	// out-of-order commands and stray codes
	task automatic noise();
		repeat ($urandom_range(4, 1))
			run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom), 50);
	endtask

	task automatic random_phase(logic [7:0] half, logic [7:0] timeout, int budget);
		int goal;
		configure(half, timeout);
		goal = items_sent + budget;
		while (items_sent < goal) begin
			if ($urandom_range(99) < 20) noise();
			else transaction();
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 18;
		recv_idle_pct = 73;

		// zero delay and zero timeout, each command at least once and the corner cases
		configure(8'd0, 8'd0);
		run_command(ACT_START, 8'h00, 1'b0, 50);
		run_command(ACT_WRITE, 8'hFF, 1'b1, 50);
		// slave never answers: first high poll fails and a stop follows
		run_command(ACT_CHECK_ACK, 8'h00, 1'b0, 0);
		// stray codes leave the error flag alone
		send_item(ACT_SPARE_LO, 8'hFF, 1'b1, 1'b0);
		send_item(ACT_SPARE_HI, 8'h00, 1'b0, 1'b1);
		// slave answers at once; the new check clears the error
		run_command(ACT_CHECK_ACK, 8'hFF, 1'b1, 100);
		run_command(ACT_WRITE, 8'h00, 1'b0, 50);
		run_command(ACT_READ, 8'h00, 1'b1, 100);
		run_command(ACT_READ, 8'hFF, 1'b0, 0);
		// a stop while the start is still running is refused
		send_item(ACT_START, 8'h5A, 1'b0, 1'b1);
		run_command(ACT_STOP, 8'hA5, 1'b1, 50);
		run_command(ACT_STOP, 8'h00, 1'b0, 50);

		random_phase(8'd1, 8'd4, 220);
		random_phase(8'd2, 8'd1, 170);

		send_idle_pct = 73;
		recv_idle_pct = 18;
		random_phase(8'd1, 8'd255, 170);
		random_phase(8'd3, 8'd2, 170);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// longest delay: keep it to a start
		configure(8'd255, 8'd3);
		run_command(ACT_START, 8'($urandom), 1'($urandom), 50);
		random_phase(8'd5, 8'd250, 120);
		random_phase(8'd1, 8'd1, 170);

		settle();
		repeat (4) @(negedge clk);

		$display("Checked %0d tick results: %0d bus commands finished, %0d refused while busy,",
			results_checked, commands_done, rejected_cmds);
		$display("%0d acknowledge timeouts, delays 0 to 255 and timeouts 0 to 255 covered.",
			ack_timeouts);
		if (mismatches == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// hard stop for a hung handshake
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
